FILE: rtl/mhdr_pkg.sv
// Shared types and constants for the max-heap delete-root block.
// No dependencies; imported by mhdr_ctrl and max_heap_delete_root.
`timescale 1ns / 1ps
`default_nettype none

package mhdr_pkg;

  localparam int unsigned CAPACITY_DEF = 128;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned COUNT_OUT_W  = 8;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed;
    logic [COUNT_OUT_W-1:0]   count;
    status_e                  status;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/mhdr_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mhdr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b_i,
  output logic      [WIDTH-1:0]         rd_data_a_o,
  output logic      [WIDTH-1:0]         rd_data_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_a_o <= mem[rd_addr_a_i];
    rd_data_b_o <= mem[rd_addr_b_i];
  end

endmodule

`default_nettype wire

FILE: rtl/mhdr_ctrl.sv
// Heap controller: entry count, command decode and the sift-down sequencer.
// Depends on mhdr_pkg; drives the ports of one mhdr_ram instance.
`timescale 1ns / 1ps
`default_nettype none

module mhdr_ctrl import mhdr_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        command_i,
  input  wire logic signed [DATA_W-1:0]    value_i,
  output logic                             res_valid_o,
  input  wire logic                        res_ready_i,
  output result_t                          res_o,
  output logic                             wr_en_o,
  output logic [$clog2(CAPACITY)-1:0]      wr_addr_o,
  output logic [DATA_W-1:0]                wr_data_o,
  output logic [$clog2(CAPACITY)-1:0]      rd_addr_a_o,
  output logic [$clog2(CAPACITY)-1:0]      rd_addr_b_o,
  input  wire logic [DATA_W-1:0]           rd_data_a_i,
  input  wire logic [DATA_W-1:0]           rd_data_b_i
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_RD_ROOT  = 5'b00010,
    S_SIFT_RD  = 5'b00100,
    S_SIFT_CMP = 5'b01000,
    S_FINISH   = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     cur_q, cur_d;
  logic [DATA_W-1:0] x_q, x_d;
  logic [DATA_W-1:0] removed_q, removed_d;
  status_e           status_q, status_d;

  // heap positions are 1-based, stored at address position - 1
  logic [CW:0]       left_pos, right_pos, cnt_ext, big_pos;
  logic              take_right;
  logic [DATA_W-1:0] big_val;

  assign left_pos   = {cur_q, 1'b0};
  assign right_pos  = left_pos + 1'b1;
  assign cnt_ext    = {1'b0, cnt_q};
  assign take_right = (right_pos <= cnt_ext) &&
                      !($signed(rd_data_a_i) > $signed(rd_data_b_i));
  assign big_val    = take_right ? rd_data_b_i : rd_data_a_i;
  assign big_pos    = take_right ? right_pos : left_pos;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    x_d         = x_q;
    removed_d   = removed_q;
    status_d    = status_q;
    rd_addr_a_o = AW'(left_pos - 1'b1);
    rd_addr_b_o = AW'(left_pos);
    wr_en_o     = 1'b0;
    wr_addr_o   = AW'(cur_q - 1'b1);
    wr_data_o   = x_q;
    unique case (state_q)
      S_IDLE: begin
        // root and last entry, read ahead for a delete
        rd_addr_a_o = '0;
        rd_addr_b_o = AW'(cnt_q - 1'b1);
        if (in_valid_i) begin
          removed_d = '0;
          status_d  = ST_OK;
          state_d   = S_FINISH;
          if (command_i == CMD_LOAD) begin
            if (cnt_q == CW'(CAPACITY)) begin
              status_d = ST_FULL;
            end else begin
              wr_en_o   = 1'b1;
              wr_addr_o = AW'(cnt_q);
              wr_data_o = value_i;
              cnt_d     = cnt_q + 1'b1;
            end
          end else if (cnt_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            cnt_d   = cnt_q - 1'b1;
            state_d = S_RD_ROOT;
          end
        end
      end
      S_RD_ROOT: begin
        removed_d = rd_data_a_i;
        x_d       = rd_data_b_i;
        cur_d     = CW'(1);
        state_d   = S_SIFT_RD;
      end
      S_SIFT_RD: begin
        // no children left: the moving entry settles here
        if (left_pos > cnt_ext) begin
          wr_en_o = 1'b1;
          state_d = S_FINISH;
        end else begin
          state_d = S_SIFT_CMP;
        end
      end
      S_SIFT_CMP: begin
        wr_en_o = 1'b1;
        if ($signed(big_val) > $signed(x_q)) begin
          wr_data_o = big_val;
          cur_d     = CW'(big_pos);
          state_d   = S_SIFT_RD;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    x_q       <= x_d;
    removed_q <= removed_d;
    status_q  <= status_d;
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign res_valid_o    = (state_q == S_FINISH);
  assign res_o.removed  = removed_q;
  assign res_o.count    = COUNT_OUT_W'(cnt_q);
  assign res_o.status   = status_q;

endmodule

`default_nettype wire

FILE: rtl/max_heap_delete_root.sv
// Top level of the max-heap delete-root block: controller, heap RAM, output register.
// Depends on mhdr_pkg, mhdr_ram and mhdr_ctrl.
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, command_i, value_i       | into block
//   out     | out_valid_o, out_stall_i, removed_value_o,       | out of block
//           | count_o, status_o                                |
//
// One transaction at a time. A load or a flagged command passes through S_FINISH to the
// output register. A delete reads the root and the last entry, then sinks that entry
// L levels until it ends at a leaf or stops above the leaves. L is the number of levels
// the entry sinks (at most log2 of the count); each level costs one RAM read and one compare.
// Reset empties the heap at once; RAM contents are not cleared.
// A stalled output holds its transaction while the next one is already being worked.
`timescale 1ns / 1ps
`default_nettype none

module max_heap_delete_root import mhdr_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          command_i,
  input  wire logic signed [DATA_W-1:0]      value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [DATA_W-1:0]           removed_value_o,
  output logic [COUNT_OUT_W-1:0]             count_o,
  output logic [1:0]                         status_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic              res_valid, res_ready;
  result_t           res, out_res_q;
  logic              out_valid_q, out_valid_d;

  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr_a, rd_addr_b;
  logic [DATA_W-1:0] wr_data, rd_data_a, rd_data_b;

  mhdr_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b),
    .rd_data_a_i (rd_data_a),
    .rd_data_b_i (rd_data_b)
  );

  mhdr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  // output register is free when empty or being drained this cycle
  assign res_ready   = !out_valid_q || !out_stall_i;
  assign out_valid_d = (res_valid && res_ready) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = out_res_q.removed;
  assign count_o         = out_res_q.count;
  assign status_o        = out_res_q.status;

  // one transaction in flight: intake closes right after an accept
  a_single_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while previous transaction still in flight");

  a_err_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> removed_value_o == '0)
    else $error("flagged transaction carries a removed value");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> count_o == COUNT_OUT_W'(CAPACITY))
    else $error("full flag with count below capacity");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> count_o == '0)
    else $error("empty flag with nonzero count");

endmodule

`default_nettype wire

FILE: sim/mhdr_checker.sv
`timescale 1ns / 1ps
// Checker for max_heap_delete_root: watches both channels, keeps a shadow heap,
// compares each result transaction. Depends on mhdr_pkg.
module mhdr_checker import mhdr_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic                     command_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [DATA_W-1:0] removed_value_i,
  input  logic [COUNT_OUT_W-1:0]   count_i,
  input  logic [1:0]               status_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  logic signed [DATA_W-1:0] heap_mem [1:CAPACITY];
  int unsigned              heap_size;
  result_t                  expected_q [$];
  int                       fails;

  task automatic log_failure(input string msg);
    if (fails < 10) $display("%t: %s", $realtime, msg);
    fails++;
  endtask

  // Applies one command to the shadow heap and returns the result it should yield.
  task automatic heap_apply(input cmd_e op, input logic signed [DATA_W-1:0] v,
                            output result_t r);
    int unsigned              cur;
    int unsigned              big;
    logic signed [DATA_W-1:0] tmp;
    bit                       settled;
    r.removed = '0;
    r.status  = ST_OK;
    if (op == CMD_LOAD) begin
      if (heap_size >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        heap_size++;
        heap_mem[heap_size] = v;
      end
    end else if (heap_size == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.removed   = heap_mem[1];
      heap_mem[1] = heap_mem[heap_size];
      heap_size--;
      cur     = 1;
      settled = 1'b0;
      while (!settled && 2 * cur <= heap_size) begin
        big = 2 * cur;
        // ties between children go to the right one
        if (big + 1 <= heap_size && !(heap_mem[big] > heap_mem[big + 1])) big = big + 1;
        if (heap_mem[big] > heap_mem[cur]) begin
          tmp           = heap_mem[cur];
          heap_mem[cur] = heap_mem[big];
          heap_mem[big] = tmp;
          cur           = big;
        end else begin
          settled = 1'b1;
        end
      end
    end
    r.count = heap_size[COUNT_OUT_W-1:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      heap_size = 0;
      expected_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          log_failure($sformatf("unexpected result: removed=%0d count=%0d status=%0d",
                                removed_value_i, count_i, status_i));
        end else begin
          want = expected_q.pop_front();
          if (removed_value_i !== want.removed || count_i !== want.count ||
              status_i !== want.status) begin
            log_failure($sformatf({"mismatch: expected removed=%0d count=%0d status=%0d,",
                                   " got removed=%0d count=%0d status=%0d"},
                                  want.removed, want.count, want.status,
                                  removed_value_i, count_i, status_i));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        heap_apply(cmd_e'(command_i), value_i, want);
        expected_q.push_back(want);
      end
      fail_count_o <= fails;
      pending_o    <= expected_q.size();
    end
  end

endmodule

FILE: sim/tb_max_heap_delete_root.sv
`timescale 1ns / 1ps
// Testbench top for max_heap_delete_root: clock, reset, stimulus and verdict.
// Depends on mhdr_pkg, the block's RTL and mhdr_checker.
module tb_max_heap_delete_root;
  import mhdr_pkg::*;

  localparam int unsigned CAP          = CAPACITY_DEF;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          PHASE_ITEMS  = 358;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh80000000;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     command_i   = 1'b0;
  logic signed [DATA_W-1:0] value_i     = '0;
  logic                     out_stall_i = 1'b0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic signed [DATA_W-1:0] removed_value_o;
  logic [COUNT_OUT_W-1:0]   count_o;
  logic [1:0]               status_o;

  int          fail_count;
  int          pending;
  int          cycle_cnt     = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_req      = 0;
  int          hold_seen     = 0;
  int          hold_left     = 0;
  int unsigned fill_level    = 0;
  longint      floor_val     = 0;

  max_heap_delete_root #(.CAPACITY(CAP)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .value_i,
    .out_valid_o, .out_stall_i, .removed_value_o, .count_o, .status_o
  );

  mhdr_checker #(.CAPACITY(CAP)) u_checker (
    .clk_i, .rst_ni, .in_valid_i,
    .in_stall_i      (in_stall_o),
    .command_i, .value_i,
    .out_valid_i     (out_valid_o),
    .out_stall_i,
    .removed_value_i (removed_value_o),
    .count_i         (count_o),
    .status_i        (status_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when requested.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_op(input cmd_e op, input logic signed [DATA_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= op;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    if (op == CMD_LOAD && fill_level < CAP) fill_level++;
    else if (op == CMD_DELETE && fill_level > 0) fill_level--;
  endtask

  // Non-increasing values keep heap order no matter where deletes left the entries;
  // a few loads are random and break it on purpose.
  function automatic logic signed [DATA_W-1:0] next_load_value();
    longint step;
    if ($urandom_range(0, 99) < 6) return $urandom;
    if (fill_level == 0) begin
      if ($urandom_range(0, 1)) floor_val = 64'sd2147483647 - $urandom_range(0, 3);
      else floor_val = longint'($signed($urandom));
    end
    case ($urandom_range(0, 3))
      0:       step = 0;
      1:       step = $urandom_range(0, 15);
      2:       step = $urandom_range(0, 1 << 16);
      default: step = $urandom_range(0, 1 << 24);
    endcase
    floor_val = floor_val - step;
    if (floor_val < -64'sd2147483648) floor_val = -64'sd2147483648;
    return floor_val[DATA_W-1:0];
  endfunction

  task automatic run_segment(input int load_pct, input int n);
    repeat (n) begin
      if ($urandom_range(0, 99) < load_pct) send_op(CMD_LOAD, next_load_value());
      else send_op(CMD_DELETE, $urandom);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic run_phase(input int idle, input int stall, input bit do_hold);
    int remaining;
    int n;
    int extra;
    send_idle_pct = idle;
    stall_pct    <= stall;
    remaining     = PHASE_ITEMS;
    extra         = 0;
    // fill to capacity, then a few loads on the full heap
    while (fill_level < CAP || extra < 3) begin
      if ($urandom_range(0, 99) < 95) begin
        if (fill_level == CAP) extra++;
        send_op(CMD_LOAD, next_load_value());
      end else begin
        send_op(CMD_DELETE, $urandom);
      end
      remaining--;
    end
    if (do_hold) begin
      hold_req <= hold_req + 1;
      run_segment(60, 30);
      remaining -= 30;
    end
    while (remaining > 0) begin
      n = (remaining < 35) ? remaining : 35;
      case ($urandom_range(0, 2))
        0:       run_segment(75, n);
        1:       run_segment(50, n);
        default: run_segment(25, n);
      endcase
      remaining -= n;
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_op(CMD_DELETE, VAL_MAX);       // empty heap
    send_op(CMD_LOAD, VAL_MAX);
    send_op(CMD_LOAD, '0);
    send_op(CMD_LOAD, '0);              // equal children
    send_op(CMD_LOAD, VAL_MIN);
    send_op(CMD_LOAD, VAL_MIN);
    repeat (5) send_op(CMD_DELETE, VAL_MIN);
    send_op(CMD_DELETE, '1);
    send_op(CMD_LOAD, 32'sd100);
    send_op(CMD_LOAD, 32'sd70);
    send_op(CMD_LOAD, 32'sd90);
    send_op(CMD_LOAD, 32'sd70);
    send_op(CMD_LOAD, -32'sd1);
    send_op(CMD_LOAD, 32'sd500);        // out of heap order
    repeat (6) send_op(CMD_DELETE, $urandom);
    wait_drained();

    run_phase(0, 0, 1'b1);
    run_phase(47, 0, 1'b0);
    run_phase(0, 47, 1'b1);
    run_phase(33, 33, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
